/* hdl/bcs_pkg.sv */
// Package for the bad-character string search block.
// Holds the sizes, the register index codes and the controller/datapath structs.
// No dependencies.
package bcs_pkg;

	localparam int TEXT_DEPTH  = 64;
	localparam int PATTERN_MAX = 8;
	localparam int MAX_OUT     = 64;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 6;
	localparam int LEN_W      = 4;
	localparam int CFG_DATA_W = PATTERN_MAX * BYTE_W;
	localparam int CFG_IDX_W  = 1;

	localparam int TEXT_AW = $clog2(TEXT_DEPTH);
	localparam int CNT_W   = TEXT_AW + 1;
	localparam int SH_W    = CNT_W + 1;
	localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int OCNT_W  = $clog2(MAX_OUT) + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES  = 1'b0,
		CFG_PATTERN_LENGTH = 1'b1
	} bcs_cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // store an accepted text byte
		logic init;    // start a search at shift zero
		logic cmp_go;  // apply the current compare result
		logic finish;  // emit the final result and empty the buffer
	} bcs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;        // no further shift fits, or the result limit is reached
		logic full_match;  // the compare at index zero succeeded
		logic pend_valid;  // a match position is held back
		logic out_free;    // the output register can take a result
	} bcs_status_t;

endpackage

/* hdl/bcs_ctrl.sv */
// Controller state machine of the bad-character string search block.
// Sequences loading, compare steps and result emission. Depends on bcs_pkg.
module bcs_ctrl import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	input  logic        last_byte,
	output logic        text_ready,
	input  bcs_status_t status,
	output bcs_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_CHECK,
		ST_CMP,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   stall_cmp;

	// A full match must hand the held-back position to the output register first.
	assign stall_cmp = status.full_match && status.pend_valid && !status.out_free;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_LOAD) && text_valid;
		cmd.init   = (state_q == ST_INIT);
		cmd.cmp_go = (state_q == ST_CMP) && !stall_cmp;
		cmd.finish = (state_q == ST_FINISH) && status.out_free;
		text_ready = (state_q == ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (text_valid && last_byte) state_q <= ST_INIT;
				end
				ST_INIT: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= status.done ? ST_FINISH : ST_CMP;
				end
				ST_CMP: begin
					if (!stall_cmp) state_q <= ST_CHECK;
				end
				ST_FINISH: begin
					if (status.out_free) state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

/* hdl/bcs_datapath.sv */
// Datapath of the bad-character string search block: configuration registers,
// text buffer, shift and compare index, skip logic and output register. Depends on bcs_pkg.
module bcs_datapath import bcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BYTE_W-1:0]     text_byte,
	input  bcs_cmd_t              cmd,
	output bcs_status_t           status,
	output logic                  match_valid,
	input  logic                  match_ready,
	output logic [POS_W-1:0]      match_position,
	output logic                  match_found,
	output logic                  last_result
);

	logic [CFG_DATA_W-1:0] pattern_q;
	logic [LEN_W-1:0]      length_q;
	logic [CNT_W-1:0]      count_q;
	logic [SH_W-1:0]       shift_q;
	logic [IDX_W-1:0]      idx_q;
	logic [OCNT_W-1:0]     out_cnt_q;
	logic                  pend_valid_q;
	logic [POS_W-1:0]      pend_pos_q;
	logic [BYTE_W-1:0]     rdata_q;
	logic                  out_valid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic                  out_found_q;
	logic                  out_last_q;

	logic [BYTE_W-1:0] text_mem [TEXT_DEPTH];

	logic [LEN_W-1:0]   m_len;
	logic [IDX_W-1:0]   m_last;
	logic [BYTE_W-1:0]  pat_byte;
	logic [TEXT_AW-1:0] rd_addr;
	logic [SH_W:0]      end_sum;
	logic               eq;
	logic               rm_hit;
	logic [LEN_W-1:0]   rm_pos;
	logic [LEN_W-1:0]   idx_ext;
	logic [LEN_W-1:0]   skip;
	logic               push_mid;
	logic               push_fin;
	logic               store_wr;

	// Effective pattern length: zero counts as one, large values saturate.
	always_comb begin
		if (length_q == '0) begin
			m_len = LEN_W'(1);
		end else if (length_q > LEN_W'(PATTERN_MAX)) begin
			m_len = LEN_W'(PATTERN_MAX);
		end else begin
			m_len = length_q;
		end
	end

	assign m_last   = IDX_W'(m_len - LEN_W'(1));
	assign pat_byte = pattern_q[idx_q*BYTE_W +: BYTE_W];
	assign rd_addr  = TEXT_AW'(shift_q + SH_W'(idx_q));
	assign end_sum  = {1'b0, shift_q} + (SH_W+1)'(m_len);
	assign eq       = (pat_byte == rdata_q);
	assign idx_ext  = LEN_W'(idx_q);

	// Rightmost position of the mismatching text byte within the active pattern.
	// The highest matching index wins, so the ascending loop keeps the last hit.
	always_comb begin
		rm_hit = 1'b0;
		rm_pos = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if ((LEN_W'(k) < m_len) && (pattern_q[k*BYTE_W +: BYTE_W] == rdata_q)) begin
				rm_hit = 1'b1;
				rm_pos = LEN_W'(k);
			end
		end
	end

	always_comb begin
		if (!rm_hit) begin
			skip = idx_ext + LEN_W'(1);
		end else if (rm_pos >= idx_ext) begin
			skip = LEN_W'(1);
		end else begin
			skip = idx_ext - rm_pos;
		end
	end

	assign status.done       = (end_sum > (SH_W+1)'(count_q)) ||
	                           (out_cnt_q >= OCNT_W'(MAX_OUT));
	assign status.full_match = eq && (idx_q == '0);
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = !out_valid_q || match_ready;

	assign push_mid = cmd.cmp_go && status.full_match && pend_valid_q;
	assign push_fin = cmd.finish;
	assign store_wr = cmd.load && (count_q < CNT_W'(TEXT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			length_q     <= LEN_W'(1);
			count_q      <= '0;
			shift_q      <= '0;
			idx_q        <= '0;
			out_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (bcs_cfg_idx_t'(cfg_index))
					CFG_PATTERN_BYTES:  pattern_q <= cfg_data;
					CFG_PATTERN_LENGTH: length_q  <= cfg_data[LEN_W-1:0];
					default:            pattern_q <= pattern_q;
				endcase
			end
			if (store_wr) count_q <= count_q + CNT_W'(1);
			if (cmd.finish) count_q <= '0;
			if (cmd.init) begin
				shift_q      <= '0;
				idx_q        <= m_last;
				out_cnt_q    <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.cmp_go) begin
				if (!eq) begin
					shift_q <= shift_q + SH_W'(skip);
					idx_q   <= m_last;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - IDX_W'(1);
				end else begin
					shift_q      <= shift_q + SH_W'(1);
					idx_q        <= m_last;
					out_cnt_q    <= out_cnt_q + OCNT_W'(1);
					pend_valid_q <= 1'b1;
				end
			end
			if (push_mid || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (match_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) text_mem[count_q[TEXT_AW-1:0]] <= text_byte;
		rdata_q <= text_mem[rd_addr];
		if (cmd.cmp_go && status.full_match) pend_pos_q <= shift_q[POS_W-1:0];
		if (push_mid) begin
			out_pos_q   <= pend_pos_q;
			out_found_q <= 1'b1;
			out_last_q  <= 1'b0;
		end else if (push_fin) begin
			out_pos_q   <= pend_valid_q ? pend_pos_q : '0;
			out_found_q <= pend_valid_q;
			out_last_q  <= 1'b1;
		end
	end

	assign match_valid    = out_valid_q;
	assign match_position = out_pos_q;
	assign match_found    = out_found_q;
	assign last_result    = out_last_q;

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push_mid || push_fin) |-> (!out_valid_q || match_ready))
		else $error("result pushed into an occupied output register");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TEXT_DEPTH))
		else $error("text count beyond buffer depth");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (count_q == '0))
		else $error("text count not cleared after a search");

	a_result_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= OCNT_W'(MAX_OUT))
		else $error("result count beyond its limit");

endmodule

/* hdl/bad_character_string_search.sv */
// Top level of the bad-character string search block.
// Instantiates bcs_ctrl and bcs_datapath; depends on bcs_pkg.
//
//   Channel   Signals                                        Direction  Handshake
//   text      text_byte, last_byte                           in         text_valid / text_ready
//   match     match_position, match_found, last_result       out        match_valid / match_ready
//   config    cfg_index, cfg_data                            in         cfg_write (no wait)
//
// Loading accepts one text byte per cycle while text_ready is high; bytes past the 64-entry buffer are dropped.
// After the transfer that carries last_byte, the search passes a setup state, then for
// each character compare a state that reads the single buffer port and one that compares
// and steps, then a check that finds the search done and a state to emit the final result.
// Reset clears all control state; buffer contents are undefined until written.
// A stalled match port holds back the search when a second match is found while a result
// still waits, and holds the final result until the output register is free; new text is
// taken while the final result waits to be taken.
module bad_character_string_search import bcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  last_byte,
	output logic                  match_valid,
	input  logic                  match_ready,
	output logic [POS_W-1:0]      match_position,
	output logic                  match_found,
	output logic                  last_result
);

	// Commands flow from the controller to the datapath, status flows back.
	bcs_cmd_t    cmd;
	bcs_status_t status;

	// The controller decides when a byte transfer is taken and when each
	// compare step or result emission may proceed.
	bcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.last_byte  (last_byte),
		.text_ready (text_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// The datapath holds the pattern, the text buffer, the search position and
	// the output register. The rightmost position of a byte in the pattern is
	// found by comparing it against every active pattern byte at once.
	bcs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_byte      (text_byte),
		.cmd            (cmd),
		.status         (status),
		.match_valid    (match_valid),
		.match_ready    (match_ready),
		.match_position (match_position),
		.match_found    (match_found),
		.last_result    (last_result)
	);

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bad_character_string_search: drives text bytes, predicts the
// match results of each search and checks them in order. Depends on bcs_pkg and the RTL.
module tb;
	import bcs_pkg::*;

	// A text byte as the sender presents it, and one search result as the block reports it.
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} text_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
		logic             last;
	} match_result_t;

	// Pauses between phases cover the block finishing a byte load before a register write.
	localparam int SETTLE_CYCLES = 16;
	// The slowest search walks about 460 compares, each through a check and a compare state,
	// with nothing moving; the limit leaves a wide margin over that plus the longest stalls on both sides.
	localparam int QUIET_LIMIT   = 6000;
	localparam int RANDOM_BYTES  = 310;

	// Every input starts at a known value; reset is held low from time zero.
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = CFG_PATTERN_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  text_valid  = 1'b0;
	logic                  text_ready;
	logic [BYTE_W-1:0]     text_byte   = '0;
	logic                  last_byte   = 1'b0;
	logic                  match_valid;
	logic                  match_ready = 1'b0;
	logic [POS_W-1:0]      match_position;
	logic                  match_found;
	logic                  last_result;

	bad_character_string_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_valid     (text_valid),
		.text_ready     (text_ready),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.match_valid    (match_valid),
		.match_ready    (match_ready),
		.match_position (match_position),
		.match_found    (match_found),
		.last_result    (last_result)
	);

	always #4 clk = ~clk;

	// Stimulus queue filled by the sequence below and drained by the sender.
	text_item_t    text_to_send[$];
	// Results the search model has produced and the block has not yet delivered.
	match_result_t expected_matches[$];

	// The testbench's own copy of the block state: the configured pattern and the text
	// collected since the last search.
	logic [CFG_DATA_W-1:0] pattern_now = '0;
	logic [LEN_W-1:0]      length_now  = 4'd1;
	logic [BYTE_W-1:0]     text_buf [0:TEXT_DEPTH-1];
	int                    text_len    = 0;

	// Idle behavior per side: 0 never waits, 1 waits now and then, 2 draws a wait for every item.
	int send_mode = 0;
	int recv_mode = 0;
	int send_wait = 0;
	int recv_wait = 0;

	int mismatches     = 0;
	int bytes_sent     = 0;
	int searches_done  = 0;
	int match_count    = 0;
	int miss_count     = 0;
	int overflow_texts = 0;
	int quiet_cycles   = 0;

	// Text under construction before it is queued for the sender.
	logic [BYTE_W-1:0] text_draft [0:79];
	int                draft_len   = 0;
	int                queued_bytes = 0;

	text_item_t    next_item;
	match_result_t got_result;
	match_result_t want_result;
	int            stall;

	function automatic int draw_gap(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : 0;
		return $urandom_range(0, 14);
	endfunction

	// Takes one accepted text byte. A byte marked last runs the bad-character search over
	// the stored text and appends its results, in rising position order, to the queue.
	function automatic void search_text_for_pattern(input logic [BYTE_W-1:0] value,
			input logic last);
		int            plen;
		int            shift;
		int            j;
		int            skip;
		int            hits;
		int            k;
		int            rightmost_of [0:255];
		logic [7:0]    seen;
		match_result_t res;
		// Bytes past the end of the buffer are dropped, but their last mark still counts.
		if (text_len < TEXT_DEPTH) begin
			text_buf[text_len] = value;
			text_len++;
		end
		if (!last)
			return;
		// A length of zero acts as one; anything above the pattern width acts as the width.
		plen = (length_now == 0) ? 1 : ((length_now > PATTERN_MAX) ? PATTERN_MAX : length_now);
		for (k = 0; k < 256; k++)
			rightmost_of[k] = -1;
		for (k = 0; k < plen; k++)
			rightmost_of[pattern_now[8*k +: 8]] = k;
		shift = 0;
		j = plen - 1;
		hits = 0;
		while (shift + plen <= text_len && hits < MAX_OUT) begin
			seen = text_buf[shift + j];
			if (pattern_now[8*j +: 8] == seen) begin
				if (j == 0) begin
					res.position = shift[POS_W-1:0];
					res.found    = 1'b1;
					res.last     = 1'b0;
					expected_matches = {expected_matches, res};
					hits++;
					shift++;
					j = plen - 1;
				end else begin
					j--;
				end
			end else begin
				// Line the mismatched text byte up with its rightmost copy in the pattern,
				// or jump past it when the pattern lacks it; never move backward.
				skip = j - rightmost_of[seen];
				if (skip < 1)
					skip = 1;
				shift += skip;
				j = plen - 1;
			end
		end
		if (hits == 0) begin
			res.position = '0;
			res.found    = 1'b0;
			res.last     = 1'b1;
			expected_matches = {expected_matches, res};
		end else begin
			res = expected_matches.pop_back();
			res.last = 1'b1;
			expected_matches = {expected_matches, res};
		end
		text_len = 0;
	endfunction

	// Sender: presents queued bytes, holding each until its transfer, with a drawn gap
	// before each one. A back-to-back byte replaces the old one without dropping valid.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_byte  <= '0;
			last_byte  <= 1'b0;
			send_wait  <= 0;
		end else begin
			if (text_valid && text_ready) begin
				search_text_for_pattern(text_byte, last_byte);
				bytes_sent++;
			end
			if (!text_valid || text_ready) begin
				if (send_wait != 0) begin
					send_wait  <= send_wait - 1;
					text_valid <= 1'b0;
				end else if (text_to_send.size() != 0) begin
					next_item = text_to_send.pop_front();
					text_valid <= 1'b1;
					text_byte  <= next_item.value;
					last_byte  <= next_item.last;
					send_wait  <= draw_gap(send_mode);
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer against the oldest expectation, then stalls
	// for a drawn number of cycles before taking the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_ready <= 1'b0;
			recv_wait   <= 0;
		end else begin
			if (match_valid && match_ready) begin
				got_result = {match_position, match_found, last_result};
				if (expected_matches.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: position %0d found %0b last %0b",
							got_result.position, got_result.found, got_result.last);
				end else begin
					want_result = expected_matches.pop_front();
					if (got_result !== want_result) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Mismatch: expected position %0d found %0b last %0b, ",
								"got position %0d found %0b last %0b"},
								want_result.position, want_result.found, want_result.last,
								got_result.position, got_result.found, got_result.last);
					end
				end
				if (got_result.found)
					match_count++;
				else
					miss_count++;
				if (got_result.last)
					searches_done++;
				stall = draw_gap(recv_mode);
				recv_wait   <= stall;
				match_ready <= (stall == 0);
			end else if (recv_wait != 0) begin
				recv_wait   <= recv_wait - 1;
				match_ready <= (recv_wait == 1);
			end else begin
				match_ready <= 1'b1;
			end
		end
	end

	// Watchdog: any cycle with a transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (text_valid && text_ready) || (match_valid && match_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Watchdog expired after %0d quiet cycles with %0d results outstanding",
			quiet_cycles, expected_matches.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic put_char(input logic [BYTE_W-1:0] c);
		text_draft[draft_len] = c;
		draft_len++;
	endtask

	// Queues the drafted text for the sender with the last mark on its final byte.
	task automatic send_draft();
		int         i;
		text_item_t entry;
		@(negedge clk);
		for (i = 0; i < draft_len; i++) begin
			entry.value  = text_draft[i];
			entry.last   = (i == draft_len - 1);
			text_to_send = {text_to_send, entry};
		end
		if (draft_len > TEXT_DEPTH)
			overflow_texts++;
		queued_bytes += draft_len;
		draft_len = 0;
	endtask

	// Waits until every byte has gone and every result has come back, then lets any
	// byte load still in flight settle.
	task automatic wait_until_idle();
		do
			@(negedge clk);
		while (text_to_send.size() != 0 || text_valid || expected_matches.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Starts a phase: drains the block, writes both registers and picks the idle behavior.
	task automatic start_phase(input logic [CFG_DATA_W-1:0] pattern, input logic [3:0] plen,
			input int smode, input int rmode);
		logic [63:0] filler;
		wait_until_idle();
		filler = {$urandom, $urandom};
		@(posedge clk);
		cfg_write   <= 1'b1;
		cfg_index   <= CFG_PATTERN_BYTES;
		cfg_data    <= pattern;
		pattern_now  = pattern;
		@(posedge clk);
		cfg_index   <= CFG_PATTERN_LENGTH;
		cfg_data    <= {filler[63:4], plen};
		length_now   = plen;
		@(posedge clk);
		cfg_write   <= 1'b0;
		send_mode    = smode;
		recv_mode    = rmode;
	endtask

	initial begin
		int          i;
		int          k;
		int          n;
		int          style;
		int          plant_at;
		int          texts;
		int          plen_eff;
		int          random_start;
		logic [7:0]  alpha [0:2];
		logic [7:0]  fill_char;
		logic [63:0] pattern;
		logic [3:0]  plen;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The reset settings first: a one-byte pattern of zero, found only
		// after skipping a byte that the pattern does not hold.
		start_phase(64'h0, 4'd1, 0, 0);
		put_char(8'hFF); put_char(8'h00); send_draft();

		// Length zero acts as one: two separate single-byte matches.
		start_phase(64'h0000_0000_0000_00FF, 4'd0, 1, 2);
		put_char(8'hFF); put_char(8'h00); put_char(8'hFF); send_draft();

		// Length fifteen acts as eight. A text shorter than the pattern gives no match, a
		// text equal to it matches at zero, and a lone byte again gives no match.
		start_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 2, 1);
		for (i = 0; i < 3; i++)
			put_char(8'hFF);
		send_draft();
		for (i = 0; i < 8; i++)
			put_char(8'hFF);
		send_draft();
		put_char(8'h00); send_draft();

		// A pattern with a repeated byte: a mismatch lines a text byte up with its copy in the
		// pattern for a skip of two; overlapping matches at zero and three.
		start_phase(64'hFFFF_FFFF_6163_6261, 4'd4, 2, 2);
		put_char("a"); put_char("b"); put_char("c"); put_char("a");
		put_char("b"); put_char("c"); put_char("a"); put_char("z");
		send_draft();

		// Random part. It opens at the buffer limits: a one-byte pattern against a full
		// buffer of that byte gives the most results a search can return, then a text that
		// overruns the buffer and carries its last mark on a dropped byte.
		random_start = queued_bytes;
		fill_char = 8'($urandom_range(0, 255));
		start_phase({$urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), fill_char}, 4'd1, 1, 1);
		for (i = 0; i < TEXT_DEPTH; i++)
			put_char(fill_char);
		send_draft();
		n = $urandom_range(TEXT_DEPTH + 1, TEXT_DEPTH + 8);
		for (i = 0; i < n; i++)
			put_char($urandom_range(0, 1) ? fill_char : 8'($urandom_range(0, 255)));
		send_draft();

		// Then phases of short texts over a small alphabet, so that patterns recur and
		// repeat bytes, with full-range bytes mixed in and now and then a long text.
		while (queued_bytes - random_start < RANDOM_BYTES) begin
			for (k = 0; k < 3; k++)
				alpha[k] = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0:       plen = 4'd0;
				1:       plen = 4'($urandom_range(PATTERN_MAX + 1, 15));
				default: plen = 4'($urandom_range(1, PATTERN_MAX));
			endcase
			plen_eff = (plen == 0) ? 1 : ((plen > PATTERN_MAX) ? PATTERN_MAX : plen);
			for (k = 0; k < PATTERN_MAX; k++)
				pattern[8*k +: 8] = ($urandom_range(0, 3) != 0) ? alpha[$urandom_range(0, 2)]
					: 8'($urandom_range(0, 255));
			start_phase(pattern, plen, $urandom_range(0, 2), $urandom_range(0, 2));
			texts = $urandom_range(3, 8);
			for (i = 0; i < texts; i++) begin
				n = ($urandom_range(0, 24) == 0) ? $urandom_range(TEXT_DEPTH + 1, TEXT_DEPTH + 8)
					: $urandom_range(1, 20);
				style = $urandom_range(0, 3);
				for (k = 0; k < n; k++)
					put_char((style == 0 || $urandom_range(0, 5) == 0)
						? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, 2)]);
				// Most texts get a planted copy of the pattern, clipped at the text's end.
				if (style != 3) begin
					plant_at = $urandom_range(0, n - 1);
					for (k = 0; k < plen_eff && plant_at + k < n; k++)
						text_draft[plant_at + k] = pattern[8*k +: 8];
				end
				send_draft();
			end
		end

		wait_until_idle();
		repeat (40) @(posedge clk);
		$display("Covered %0d text bytes in %0d searches: %0d match and %0d no-match results.",
			bytes_sent, searches_done, match_count, miss_count);
		$display("Pattern lengths of zero, one to eight and above eight were configured; %0d %s",
			overflow_texts, "texts overran the buffer.");
		if (mismatches == 0 && expected_matches.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
